### rtl/lssc_pkg.sv
// shared types and constants for the log-scaled status colour mapper
package lssc_pkg;

  // field widths
  localparam int CNT_W     = 31;
  localparam int SCALE_W   = 24;
  localparam int IDX_W     = 8;
  localparam int K_W       = 5;
  localparam int FRAC_W    = 8;
  localparam int LOG_W     = K_W + FRAC_W;
  localparam int PROD_W    = LOG_W + SCALE_W;
  localparam int SQ_STAGES = FRAC_W;

  // reset value of the scale register, 1.0 in Q8.16
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // what the front decided about a pixel
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_BOUNDARY,
    KIND_PEOPLE,
    KIND_INFECTED,
    KIND_TREATED,
    KIND_RECOVERED
  } kind_t;

  // one queue entry: the kind and the count that sets the shade
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] count;
  } entry_t;

  // log2 pipeline stage contents
  typedef struct packed {
    kind_t             kind;
    logic [K_W-1:0]    k;
    logic [CNT_W-1:0]  m;
    logic [FRAC_W-1:0] frac;
  } sq_t;

endpackage

### rtl/lssc_front.sv
// front stage: accepts pixels and picks band and count by priority
module lssc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 is_boundary,
  input  logic [lssc_pkg::CNT_W-1:0]           infected_count,
  input  logic [lssc_pkg::CNT_W-1:0]           treated_count,
  input  logic [lssc_pkg::CNT_W-1:0]           recovered_count,
  input  logic [lssc_pkg::CNT_W-1:0]           people_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lssc_pkg::entry_t                     out_data
);

  lssc_pkg::entry_t cls;

  // priority classification
  always_comb begin
    cls.kind  = lssc_pkg::KIND_ZERO;
    cls.count = lssc_pkg::CNT_W'(1);
    if (is_boundary) begin
      cls.kind = lssc_pkg::KIND_BOUNDARY;
    end else if (infected_count != '0) begin
      cls.kind  = lssc_pkg::KIND_INFECTED;
      cls.count = infected_count;
    end else if (treated_count != '0) begin
      cls.kind  = lssc_pkg::KIND_TREATED;
      cls.count = treated_count;
    end else if (recovered_count != '0) begin
      cls.kind  = lssc_pkg::KIND_RECOVERED;
      cls.count = recovered_count;
    end else if (people_count != '0) begin
      cls.kind  = lssc_pkg::KIND_PEOPLE;
      cls.count = people_count;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= cls;
    end
  end

endmodule

### rtl/lssc_fifo.sv
// short queue that decouples the front from the log pipeline
module lssc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  lssc_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lssc_pkg::entry_t pop_data
);

  lssc_pkg::entry_t                    mem [lssc_pkg::FIFO_DEPTH];
  logic [lssc_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [lssc_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic [lssc_pkg::FIFO_CNT_W-1:0]     count;
  logic                                do_push;
  logic                                do_pop;

  assign push_ready = count != lssc_pkg::FIFO_CNT_W'(lssc_pkg::FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/lssc_back.sv
// back end: log2 by repeated squaring, scale multiply, band offset
module lssc_back #(
  parameter int SHADES = 58
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [lssc_pkg::SCALE_W-1:0]         scale,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lssc_pkg::entry_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lssc_pkg::IDX_W-1:0]           palette_index
);

  // normalize, eight squarings, scale multiply, output
  localparam int NS = lssc_pkg::SQ_STAGES + 3;
  localparam int MUL_ST = lssc_pkg::SQ_STAGES + 1;
  localparam int OUT_ST = lssc_pkg::SQ_STAGES + 2;
  localparam logic [lssc_pkg::IDX_W-1:0] TOP_SHADE = lssc_pkg::IDX_W'(SHADES - 1);
  localparam logic [lssc_pkg::IDX_W-1:0] OFF_RED   = lssc_pkg::IDX_W'(SHADES);
  localparam logic [lssc_pkg::IDX_W-1:0] OFF_BLUE  = lssc_pkg::IDX_W'(2 * SHADES);
  localparam logic [lssc_pkg::IDX_W-1:0] OFF_GREEN = lssc_pkg::IDX_W'(3 * SHADES);

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  lssc_pkg::sq_t                       st [lssc_pkg::SQ_STAGES + 1];
  lssc_pkg::sq_t                       norm;
  logic [lssc_pkg::K_W-1:0]            lead;
  lssc_pkg::kind_t                     mul_kind;
  logic [lssc_pkg::PROD_W-1:0]         prod;
  logic [lssc_pkg::LOG_W-1:0]          shade_raw;
  logic [lssc_pkg::IDX_W-1:0]          shade;
  logic [lssc_pkg::IDX_W-1:0]          idx_next;

  // stall chain: a stage moves when it is empty or its successor moves
  assign rdy[NS] = out_ready;
  for (genvar g = 0; g < NS; g++) begin : g_ctl
    assign rdy[g] = !v[g] || rdy[g+1];
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[OUT_ST];

  // leading one and normalization to Q1.30
  always_comb begin
    lead = '0;
    for (int i = 0; i < lssc_pkg::CNT_W; i++) begin
      if (in_data.count[i]) begin
        lead = lssc_pkg::K_W'(i);
      end
    end
    norm.kind = in_data.kind;
    norm.k    = lead;
    norm.m    = in_data.count << (lssc_pkg::K_W'(lssc_pkg::CNT_W - 1) - lead);
    norm.frac = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st[0] <= norm;
    end
  end

  // one fraction bit per squaring stage, msb first
  for (genvar g = 1; g <= lssc_pkg::SQ_STAGES; g++) begin : g_sq
    logic [2*lssc_pkg::CNT_W-1:0] sq;
    logic [lssc_pkg::CNT_W:0]     q;
    lssc_pkg::sq_t                nxt;

    always_comb begin
      sq       = (2*lssc_pkg::CNT_W)'(st[g-1].m) * (2*lssc_pkg::CNT_W)'(st[g-1].m);
      q        = sq[2*lssc_pkg::CNT_W-1:lssc_pkg::CNT_W-1];
      nxt      = st[g-1];
      nxt.frac = {st[g-1].frac[lssc_pkg::FRAC_W-2:0], q[lssc_pkg::CNT_W]};
      nxt.m    = q[lssc_pkg::CNT_W] ? q[lssc_pkg::CNT_W:1] : q[lssc_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        st[g] <= nxt;
      end
    end
  end

  // log value times scale
  always_ff @(posedge clk) begin
    if (rdy[MUL_ST]) begin
      mul_kind <= st[lssc_pkg::SQ_STAGES].kind;
      prod     <= lssc_pkg::PROD_W'({st[lssc_pkg::SQ_STAGES].k,
                                     st[lssc_pkg::SQ_STAGES].frac})
                * lssc_pkg::PROD_W'(scale);
    end
  end

  // floor, saturate at the band top, add band offset
  always_comb begin
    shade_raw = prod[lssc_pkg::PROD_W-1:lssc_pkg::SCALE_W];
    if (shade_raw > lssc_pkg::LOG_W'(SHADES - 1)) begin
      shade = TOP_SHADE;
    end else begin
      shade = shade_raw[lssc_pkg::IDX_W-1:0];
    end
    case (mul_kind)
      lssc_pkg::KIND_ZERO:      idx_next = '0;
      lssc_pkg::KIND_BOUNDARY:  idx_next = TOP_SHADE;
      lssc_pkg::KIND_PEOPLE:    idx_next = shade;
      lssc_pkg::KIND_INFECTED:  idx_next = OFF_RED + shade;
      lssc_pkg::KIND_TREATED:   idx_next = OFF_BLUE + shade;
      lssc_pkg::KIND_RECOVERED: idx_next = OFF_GREEN + shade;
      default:                  idx_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT_ST]) begin
      palette_index <= idx_next;
    end
  end

endmodule

### rtl/log_scaled_status_colour_mapper.sv
// top level of the log-scaled status colour mapper
// Maps one pixel's counts to an 8-bit palette index of four bands (grey,
// red, blue, green) of SHADES entries each; the shade is floor(log2(count)
// * shade_scale) with log2 taken to 8 fraction bits, saturated at the band
// top. The block takes one pixel per clock and delivers one index per clock
// when the output is not stalled. Each pixel passes the classify register,
// which loads at the accepting edge, then the queue, a normalize stage,
// eight squaring stages (one 31x31 multiplier each, one fraction bit per
// stage), the scale multiply and the output register. A four-entry queue
// between the classifier and the log pipeline lets either side stall alone.
// shade_scale is Q8.16 and resets to 1.0; write it only while idle.
module log_scaled_status_colour_mapper #(
  parameter int SHADES = 58
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: shade_scale, Q8.16
  input  logic                          cfg_wr_en,
  input  logic [lssc_pkg::SCALE_W-1:0]  cfg_wr_data,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // infected_count, treated_count, recovered_count, people_count, zero pad
  input  logic [127:0]                  s_axis_tdata,
  // is_boundary
  input  logic                          s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // palette_index
  output logic [lssc_pkg::IDX_W-1:0]    m_axis_tdata
);

  logic [lssc_pkg::SCALE_W-1:0] shade_scale;
  logic                         f_valid;
  logic                         f_ready;
  lssc_pkg::entry_t             f_data;
  logic                         q_valid;
  logic                         q_ready;
  lssc_pkg::entry_t             q_data;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      shade_scale <= lssc_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      shade_scale <= cfg_wr_data;
    end
  end

  lssc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .is_boundary     (s_axis_tuser),
    .infected_count  (s_axis_tdata[30:0]),
    .treated_count   (s_axis_tdata[61:31]),
    .recovered_count (s_axis_tdata[92:62]),
    .people_count    (s_axis_tdata[123:93]),
    .out_valid       (f_valid),
    .out_ready       (f_ready),
    .out_data        (f_data)
  );

  lssc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lssc_back #(
    .SHADES (SHADES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .scale         (shade_scale),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_data       (q_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .palette_index (m_axis_tdata)
  );

endmodule

### rtl/lssc_checker.sv
// port-level checks for the colour mapper, bound to the top level
module lssc_checker #(
  parameter int SHADES = 58
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lssc_pkg::IDX_W-1:0]    m_axis_tdata
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output item valid after reset");

  // reset leaves the input side open
  a_rst_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // index never passes the last palette entry
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 10'(m_axis_tdata) <= 10'(4 * SHADES - 1))
    else $error("palette index out of range");

endmodule

bind log_scaled_status_colour_mapper lssc_checker #(.SHADES(SHADES)) u_lssc_checker (.*);

### test/palette_index_checker.sv
`timescale 1ns / 1ps
// checker that predicts the palette index of every accepted pixel and compares results
module palette_index_checker #(
  parameter int SHADES = 58
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lssc_pkg::SCALE_W-1:0] cfg_wr_data,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // infected_count, treated_count, recovered_count, people_count, zero pad
  input  logic [127:0]                 s_axis_tdata,
  // is_boundary
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // palette_index
  input  logic [lssc_pkg::IDX_W-1:0]   m_axis_tdata,
  output int                           failures,
  output int                           pending
);

  logic [lssc_pkg::SCALE_W-1:0] shade_scale_q;
  logic [lssc_pkg::IDX_W-1:0]   expected_index_q[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report_failure(input string msg);
    $display("%t  mismatch: %s", $time, msg);
    failures++;
  endtask

  // log2 in Q5.8: leading one position, then eight squarings for the fraction
  function automatic logic [lssc_pkg::LOG_W-1:0] log2_q8_of(
      input logic [lssc_pkg::CNT_W-1:0] c);
    logic [lssc_pkg::K_W-1:0]    k;
    logic [63:0]                 m;
    logic [lssc_pkg::FRAC_W-1:0] frac;
    k = '0;
    for (int b = 1; b < lssc_pkg::CNT_W; b++) begin
      if (c[b]) k = lssc_pkg::K_W'(b);
    end
    m    = 64'(c) << (30 - int'(k));
    frac = '0;
    for (int i = 0; i < lssc_pkg::FRAC_W; i++) begin
      m    = (m * m) >> 30;
      frac = {frac[lssc_pkg::FRAC_W-2:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {k, frac};
  endfunction

  // shade within a band, floored and saturated at the band top
  function automatic logic [lssc_pkg::IDX_W-1:0] shade_of(
      input logic [lssc_pkg::CNT_W-1:0] count,
      input logic [lssc_pkg::SCALE_W-1:0] scale);
    logic [63:0] s;
    s = (64'(log2_q8_of(count)) * 64'(scale)) >> 24;
    if (s > 64'(SHADES - 1)) s = 64'(SHADES - 1);
    return lssc_pkg::IDX_W'(s);
  endfunction

  // priority classification, then band offset plus shade
  function automatic logic [lssc_pkg::IDX_W-1:0] palette_index_of(
      input logic bnd,
      input logic [lssc_pkg::CNT_W-1:0] inf,
      input logic [lssc_pkg::CNT_W-1:0] trt,
      input logic [lssc_pkg::CNT_W-1:0] rec,
      input logic [lssc_pkg::CNT_W-1:0] ppl,
      input logic [lssc_pkg::SCALE_W-1:0] scale);
    lssc_pkg::kind_t            kind;
    logic [lssc_pkg::CNT_W-1:0] count;
    count = '0;
    if (bnd) begin
      kind = lssc_pkg::KIND_BOUNDARY;
    end else if (inf != '0) begin
      kind  = lssc_pkg::KIND_INFECTED;
      count = inf;
    end else if (trt != '0) begin
      kind  = lssc_pkg::KIND_TREATED;
      count = trt;
    end else if (rec != '0) begin
      kind  = lssc_pkg::KIND_RECOVERED;
      count = rec;
    end else if (ppl != '0) begin
      kind  = lssc_pkg::KIND_PEOPLE;
      count = ppl;
    end else begin
      kind = lssc_pkg::KIND_ZERO;
    end
    case (kind)
      lssc_pkg::KIND_BOUNDARY:  return lssc_pkg::IDX_W'(SHADES - 1);
      lssc_pkg::KIND_PEOPLE:    return shade_of(count, scale);
      lssc_pkg::KIND_INFECTED:  return lssc_pkg::IDX_W'(SHADES) + shade_of(count, scale);
      lssc_pkg::KIND_TREATED:   return lssc_pkg::IDX_W'(2 * SHADES) + shade_of(count, scale);
      lssc_pkg::KIND_RECOVERED: return lssc_pkg::IDX_W'(3 * SHADES) + shade_of(count, scale);
      default:                  return '0;
    endcase
  endfunction

  // track register writes, compare results, then queue predictions
  always @(posedge clk) begin : track
    logic [lssc_pkg::IDX_W-1:0] want;
    if (rst) begin
      shade_scale_q = lssc_pkg::SCALE_RESET;
      expected_index_q.delete();
    end else begin
      if (cfg_wr_en) shade_scale_q = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_index_q.size() == 0) begin
          report_failure($sformatf("palette index %0d with none expected", m_axis_tdata));
        end else begin
          want = expected_index_q.pop_front();
          if (m_axis_tdata !== want)
            report_failure($sformatf("palette index got %0d want %0d", m_axis_tdata, want));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_index_q.push_back(palette_index_of(s_axis_tuser, s_axis_tdata[30:0],
                                                    s_axis_tdata[61:31], s_axis_tdata[92:62],
                                                    s_axis_tdata[123:93], shade_scale_q));
    end
    pending = expected_index_q.size();
  end

endmodule

### test/log_scaled_status_colour_mapper_tb.sv
`timescale 1ns / 1ps
// testbench top: drives pixels, scale writes and output back pressure, gives the verdict
module log_scaled_status_colour_mapper_tb;

  localparam int SHADES       = 58;
  localparam int CLK_HALF     = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_ITEMS   = 30;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 90;
  localparam int PHASES       = 6;
  localparam logic [lssc_pkg::CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [lssc_pkg::SCALE_W-1:0] SCALE_MAX = '1;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [lssc_pkg::SCALE_W-1:0] cfg_wr_data;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // infected_count, treated_count, recovered_count, people_count, zero pad
  logic [127:0]                 s_axis_tdata;
  // is_boundary
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // palette_index
  logic [lssc_pkg::IDX_W-1:0]   m_axis_tdata;

  int   failure_count;
  int   pending_count;
  int   quiet_cycles;
  logic no_idle;
  logic hold_request;

  log_scaled_status_colour_mapper #(
    .SHADES(SHADES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  palette_index_checker #(
    .SHADES(SHADES)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .failures     (failure_count),
    .pending      (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // output back pressure: random stall bursts, one long hold-off on request
  initial begin : receiver
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left     = 0;
    stall_left    = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one pixel and wait until it is accepted
  task automatic send_pixel(input logic bnd, input logic [lssc_pkg::CNT_W-1:0] inf,
                            input logic [lssc_pkg::CNT_W-1:0] trt,
                            input logic [lssc_pkg::CNT_W-1:0] rec,
                            input logic [lssc_pkg::CNT_W-1:0] ppl);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= bnd;
    s_axis_tdata  <= {4'b0000, ppl, rec, trt, inf};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // random input gap, skipped when no idling is asked for
  task automatic maybe_pause();
    int n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop offering, wait for every result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic [lssc_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // counts biased toward zero and the edges so every band shows up
  function automatic logic [lssc_pkg::CNT_W-1:0] rand_count();
    logic [lssc_pkg::CNT_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = '0;
      4:          v = lssc_pkg::CNT_W'(1);
      5:          v = COUNT_MAX;
      6:          v = lssc_pkg::CNT_W'(1) << $urandom_range(0, lssc_pkg::CNT_W - 1);
      7:          v = lssc_pkg::CNT_W'($urandom) >> $urandom_range(0, lssc_pkg::CNT_W - 1);
      default:    v = lssc_pkg::CNT_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [lssc_pkg::SCALE_W-1:0] phase_scale(input int p);
    case (p)
      2:       return lssc_pkg::SCALE_W'($urandom);
      3:       return lssc_pkg::SCALE_W'($urandom_range(1, 65536));
      default: return lssc_pkg::SCALE_W'($urandom_range(122000, 3801088));
    endcase
  endfunction

  // stimulus
  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pixels at the reset scale
    send_pixel(1'b0, '0, '0, '0, '0);
    send_pixel(1'b1, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
    send_pixel(1'b1, '0, '0, '0, '0);
    send_pixel(1'b0, 31'd1, '0, '0, '0);
    send_pixel(1'b0, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
    send_pixel(1'b0, '0, 31'd1, '0, '0);
    send_pixel(1'b0, '0, COUNT_MAX, COUNT_MAX, COUNT_MAX);
    send_pixel(1'b0, '0, '0, 31'd1, '0);
    send_pixel(1'b0, '0, '0, COUNT_MAX, COUNT_MAX);
    send_pixel(1'b0, '0, '0, '0, 31'd1);
    send_pixel(1'b0, '0, '0, '0, COUNT_MAX);
    send_pixel(1'b0, '0, '0, '0, 31'd2);
    send_pixel(1'b0, 31'h4000_0000, '0, '0, '0);
    send_pixel(1'b0, 31'd3, '0, '0, '0);
    drain();

    // largest scale: shades saturate at the band top, a count of one stays at 0
    write_scale(SCALE_MAX);
    send_pixel(1'b0, COUNT_MAX, '0, '0, '0);
    send_pixel(1'b0, '0, '0, '0, COUNT_MAX);
    send_pixel(1'b0, '0, 31'd2, '0, '0);
    send_pixel(1'b0, '0, '0, 31'd1, '0);
    drain();

    // zero scale: index is the band offset
    write_scale('0);
    send_pixel(1'b0, COUNT_MAX, '0, '0, '0);
    send_pixel(1'b0, '0, COUNT_MAX, '0, '0);
    send_pixel(1'b0, '0, '0, '0, 31'd12345);
    drain();

    // random phases, one with a long output hold-off, the last with no idling
    for (int p = 0; p < PHASES; p++) begin
      write_scale(phase_scale(p));
      if (p == PHASES - 1) no_idle = 1'b1;
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!(p == 1 && i < HOLD_ITEMS)) maybe_pause();
        send_pixel($urandom_range(0, 7) == 0, rand_count(), rand_count(), rand_count(),
                   rand_count());
      end
      drain();
    end

    if (failure_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
